@@ hw/rtl/rgb_led_pattern_engine_assert.svh @@
// Assertion macros shared by the pattern engine modules.
// Depends on nothing; each use names its own clock and active-low reset.
`ifndef RGB_LED_PATTERN_ENGINE_ASSERT_SVH
`define RGB_LED_PATTERN_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define RGBPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define RGBPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define RGBPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RGBPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/rgbpe_pkg.sv @@
// Shared types, codes, constants and helper functions of the pattern engine.
// Depends on nothing.
`timescale 1ns / 1ps
package rgbpe_pkg;

    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN   = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD    = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTENSITY = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REVERSE   = 4'd3;

    localparam logic [3:0] PAT_WAVE      = 4'd0;
    localparam logic [3:0] PAT_PULSE     = 4'd1;
    localparam logic [3:0] PAT_CHASE     = 4'd2;
    localparam logic [3:0] PAT_RAINBOW   = 4'd3;
    localparam logic [3:0] PAT_SPARKLE   = 4'd4;
    localparam logic [3:0] PAT_THEATER   = 4'd5;
    localparam logic [3:0] PAT_FIRE      = 4'd6;
    localparam logic [3:0] PAT_COMET     = 4'd7;
    localparam logic [3:0] PAT_HEARTBEAT = 4'd8;
    localparam logic [3:0] PAT_STROBE    = 4'd9;
    localparam logic [3:0] PAT_LAST      = PAT_STROBE;

    localparam logic [15:0] PERIOD_RESET    = 16'd50;
    localparam logic [6:0]  INTENSITY_RESET = 7'd100;
    localparam logic [6:0]  INTENSITY_MAX   = 7'd100;
    localparam logic [31:0] LCG_MUL         = 32'd1103515245;
    localparam logic [31:0] LCG_ADD         = 32'd12345;
    localparam logic [31:0] LCG_SEED_RESET  = 32'h12345678;

    // Reciprocals for exact division of 8-bit values: q = (x * M) >> 16.
    localparam int unsigned RCP_SHIFT = 16;
    localparam logic [15:0] RCP_3  = 16'((65536 + 2) / 3);
    localparam logic [15:0] RCP_10 = 16'((65536 + 9) / 10);
    localparam logic [15:0] RCP_20 = 16'((65536 + 19) / 20);
    localparam logic [15:0] RCP_56 = 16'((65536 + 55) / 56);
    localparam logic [15:0] RCP_76 = 16'((65536 + 75) / 76);

    // Intensity scaling: products below 2^15 divided by 100 as (x * M) >> 22.
    localparam int unsigned PCT_SHIFT = 22;
    localparam logic [15:0] RCP_100 = 16'((4194304 + 99) / 100);

    localparam logic [7:0] SINE_ROM [64] = '{
        8'd128, 8'd140, 8'd152, 8'd165, 8'd176, 8'd188, 8'd198, 8'd208,
        8'd218, 8'd226, 8'd234, 8'd240, 8'd245, 8'd250, 8'd253, 8'd254,
        8'd255, 8'd254, 8'd253, 8'd250, 8'd245, 8'd240, 8'd234, 8'd226,
        8'd218, 8'd208, 8'd198, 8'd188, 8'd176, 8'd165, 8'd152, 8'd140,
        8'd128, 8'd115, 8'd103, 8'd90,  8'd79,  8'd67,  8'd57,  8'd47,
        8'd37,  8'd29,  8'd21,  8'd15,  8'd10,  8'd5,   8'd2,   8'd1,
        8'd0,   8'd1,   8'd2,   8'd5,   8'd10,  8'd15,  8'd21,  8'd29,
        8'd37,  8'd47,  8'd57,  8'd67,  8'd79,  8'd90,  8'd103, 8'd115
    };

    typedef struct packed {
        logic capture;
        logic check;
        logic draw;
        logic apply;
        logic scale;
        logic divide;
        logic pwm;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic step_due;
        logic more_draws;
    } t_status;

    // Quotient of an 8-bit value by the constant whose reciprocal is given.
    function automatic logic [7:0] quot8(input logic [7:0] x, input logic [15:0] rcp);
        logic [23:0] prod;
        begin
            prod = {16'd0, x} * {8'd0, rcp};
            quot8 = prod[RCP_SHIFT +: 8];
        end
    endfunction

    // Remainder of an 8-bit value by constant d with reciprocal rcp.
    function automatic logic [7:0] rem8(input logic [7:0] x, input logic [15:0] rcp,
                                        input logic [7:0] d);
        logic [15:0] qd;
        begin
            qd = {8'd0, quot8(x, rcp)} * {8'd0, d};
            rem8 = x - qd[7:0];
        end
    endfunction

    // Remainder by three of a small counter sum.
    function automatic logic [1:0] mod3_small(input logic [2:0] x);
        begin
            case (x)
                3'd0, 3'd3, 3'd6: mod3_small = 2'd0;
                3'd1, 3'd4, 3'd7: mod3_small = 2'd1;
                default:          mod3_small = 2'd2;
            endcase
        end
    endfunction

    function automatic logic [7:0] sat_sub(input logic [7:0] x, input logic [7:0] amt);
        begin
            sat_sub = (x > amt) ? (x - amt) : 8'd0;
        end
    endfunction

endpackage

@@ hw/rtl/rgbpe_ctrl.sv @@
// Sequencer of the pattern engine: handshakes and the per-item step order.
// Depends on rgbpe_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "rgb_led_pattern_engine_assert.svh"
module rgbpe_ctrl
    import rgbpe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CMP, S_DCHK, S_DRAW, S_APPLY, S_MUL, S_DIV, S_PWM, S_DONE
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_ready;
    assign o_ready   = r_in_ready;
    assign o_valid   = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = i_valid && r_in_ready;
        o_cmd.check    = (r_state == S_CMP);
        o_cmd.draw     = (r_state == S_DRAW);
        o_cmd.apply    = (r_state == S_APPLY);
        o_cmd.scale    = (r_state == S_MUL);
        o_cmd.divide   = (r_state == S_DIV);
        o_cmd.pwm      = (r_state == S_PWM);
        o_cmd.load_out = (r_state == S_DONE) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.capture) begin
                        r_in_ready <= 1'b0;
                        r_state    <= S_CMP;
                    end
                end
                S_CMP:   r_state <= i_status.step_due ? S_DCHK : S_DONE;
                S_DCHK:  r_state <= i_status.more_draws ? S_DRAW : S_APPLY;
                S_DRAW:  r_state <= S_DCHK;
                S_APPLY: r_state <= S_MUL;
                S_MUL:   r_state <= S_DIV;
                S_DIV:   r_state <= S_PWM;
                S_PWM:   r_state <= S_DONE;
                S_DONE: begin
                    if (slot_free) begin
                        r_in_ready <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `RGBPE_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, o_cmd.capture, !r_in_ready)
    `RGBPE_ASSERT_IMP(a_ready_only_idle, i_clk, i_rst_n, r_in_ready, r_state == S_IDLE)
    `RGBPE_ASSERT_NXT(a_load_sets_valid, i_clk, i_rst_n, o_cmd.load_out, r_out_valid)

endmodule

@@ hw/rtl/rgbpe_dp.sv @@
// Datapath of the pattern engine: configuration, pattern state, LCG,
// intensity scaling, dithered PWM and the result register.
// Depends on rgbpe_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "rgb_led_pattern_engine_assert.svh"
module rgbpe_dp
    import rgbpe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [31:0]           i_tick_now,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_stepped,
    output logic [7:0]            o_red_level,
    output logic [7:0]            o_green_level,
    output logic [7:0]            o_blue_level,
    output logic                  o_red_pin,
    output logic                  o_green_pin,
    output logic                  o_blue_pin
);

    logic [3:0]  r_pattern;
    logic [15:0] r_period;
    logic [6:0]  r_pct;
    logic        r_rev;
    logic [31:0] r_tick, r_last, r_seed;
    logic [1:0]  r_phase, r_sub;
    logic [5:0]  r_pos;
    logic [7:0]  r_lvl [3];
    logic [14:0] r_prod [3];
    logic [7:0]  r_scaled [3];
    logic [7:0]  r_draw [3];
    logic [1:0]  r_draw_cnt;
    logic [7:0]  r_pwm;
    logic [3:0]  r_dither;
    logic [2:0]  r_pins;
    logic        r_stepped;

    logic [7:0]  n_lvl [3];
    logic [1:0]  n_phase, n_sub;
    logic [5:0]  n_pos;
    logic [31:0] n_seed, tick_diff;
    logic [3:0]  n_dither;
    logic [2:0]  n_pins;
    logic [7:0]  sine0, sine1, sine2, h, h3, fade10, v_fire, hb_v;
    logic [5:0]  p21, p42, hb_idx, p_off;
    logic [6:0]  pos_inc;
    logic [1:0]  ph_a, ph_b, ph_next;
    logic        spark_hit;
    logic [8:0]  thr [3];

    // Step check and draw bookkeeping.
    assign tick_diff = r_tick - r_last;
    assign spark_hit = rem8(r_draw[0], RCP_10, 8'd10) < 8'd3;

    always_comb begin
        o_status.step_due   = tick_diff >= {16'd0, r_period};
        o_status.more_draws = 1'b0;
        if (r_pattern == PAT_SPARKLE) begin
            o_status.more_draws = (r_draw_cnt == 2'd0) || (spark_hit && r_draw_cnt != 2'd3);
        end else if (r_pattern == PAT_FIRE) begin
            o_status.more_draws = r_draw_cnt < 2'd2;
        end
    end

    assign n_seed = r_seed * LCG_MUL + LCG_ADD;

    // Pattern step.
    assign p21     = r_pos + 6'd21;
    assign p42     = r_pos + 6'd42;
    assign sine0   = SINE_ROM[r_pos];
    assign sine1   = SINE_ROM[p21];
    assign sine2   = SINE_ROM[p42];
    assign h       = {r_pos, 2'b00};
    assign ph_a    = mod3_small({1'b0, r_phase});
    assign ph_b    = mod3_small({1'b0, r_phase} + 3'd2);
    assign ph_next = mod3_small({1'b0, r_phase} + 3'd1);
    assign pos_inc = {1'b0, r_pos} + 7'd1;
    assign p_off   = r_pos - 6'd15;
    assign v_fire  = 8'd180 + rem8(r_draw[0], RCP_76, 8'd76);

    always_comb begin
        hb_idx = '0;
        hb_v   = 8'd0;
        if (r_pos < 6'd10) begin
            hb_idx = {r_pos[4:0], 1'b0} + {r_pos[3:0], 2'b00};
            hb_v   = SINE_ROM[hb_idx];
        end else if (r_pos >= 6'd15 && r_pos < 6'd25) begin
            hb_idx = {p_off[4:0], 1'b0} + {p_off[3:0], 2'b00};
            hb_v   = SINE_ROM[hb_idx];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_lvl[i] = r_lvl[i];
        end
        n_phase = r_phase;
        n_sub   = r_sub;
        n_pos   = r_pos;
        h3      = 8'd0;
        fade10  = 8'd0;
        case (r_pattern)
            PAT_WAVE: begin
                n_lvl[0] = sine0;
                n_lvl[1] = sine1;
                n_lvl[2] = sine2;
                n_pos    = r_rev ? (r_pos + 6'd63) : (r_pos + 6'd1);
            end
            PAT_PULSE: begin
                for (int i = 0; i < 3; i++) begin
                    n_lvl[i] = sine0;
                end
                n_pos = r_pos + 6'd1;
            end
            PAT_CHASE: begin
                for (int i = 0; i < 3; i++) begin
                    if (ph_a == 2'(i)) begin
                        n_lvl[i] = 8'd255;
                    end else if (ph_b == 2'(i)) begin
                        n_lvl[i] = 8'd64;
                    end else begin
                        n_lvl[i] = 8'd0;
                    end
                end
                n_phase = r_rev ? mod3_small({1'b0, r_phase} + 3'd2) : ph_next;
            end
            PAT_RAINBOW: begin
                if (h < 8'd85) begin
                    h3 = h * 8'd3;
                    n_lvl[0] = 8'd255 - h3;
                    n_lvl[1] = h3;
                    n_lvl[2] = 8'd0;
                end else if (h < 8'd170) begin
                    h3 = (h - 8'd85) * 8'd3;
                    n_lvl[0] = 8'd0;
                    n_lvl[1] = 8'd255 - h3;
                    n_lvl[2] = h3;
                end else begin
                    h3 = (h - 8'd170) * 8'd3;
                    n_lvl[0] = h3;
                    n_lvl[1] = 8'd0;
                    n_lvl[2] = 8'd255 - h3;
                end
                n_pos = r_pos + 6'd1;
            end
            PAT_SPARKLE: begin
                fade10 = 8'd200 + rem8(r_draw[2], RCP_56, 8'd56);
                for (int i = 0; i < 3; i++) begin
                    n_lvl[i] = sat_sub(r_lvl[i], 8'd10);
                    if (spark_hit && rem8(r_draw[1], RCP_3, 8'd3) == 8'(i)) begin
                        n_lvl[i] = fade10;
                    end
                end
            end
            PAT_THEATER: begin
                for (int i = 0; i < 3; i++) begin
                    n_lvl[i] = (r_phase == 2'(i)) ? 8'd255 : 8'd0;
                end
                n_phase = ph_next;
                if (ph_next == 2'd0) begin
                    n_sub = mod3_small({1'b0, r_sub} + 3'd1);
                    if (n_sub == 2'd0) begin
                        for (int i = 0; i < 3; i++) begin
                            n_lvl[i] = 8'd128;
                        end
                    end
                end
            end
            PAT_FIRE: begin
                if (rem8(r_draw[1], RCP_20, 8'd20) == 8'd0) begin
                    n_lvl[0] = 8'd255;
                    n_lvl[1] = 8'd128;
                end else begin
                    n_lvl[0] = v_fire;
                    n_lvl[1] = quot8(v_fire, RCP_3);
                end
                n_lvl[2] = 8'd0;
            end
            PAT_COMET: begin
                for (int i = 0; i < 3; i++) begin
                    n_lvl[i] = (ph_a == 2'(i)) ? 8'd255 : sat_sub(r_lvl[i], 8'd20);
                end
                n_phase = ph_next;
            end
            PAT_HEARTBEAT: begin
                n_lvl[0] = hb_v;
                n_lvl[1] = 8'd0;
                n_lvl[2] = {3'd0, hb_v[7:3]};
                n_pos    = (pos_inc >= 7'd50) ? 6'(pos_inc - 7'd50) : pos_inc[5:0];
            end
            PAT_STROBE: begin
                for (int i = 0; i < 3; i++) begin
                    n_lvl[i] = r_phase[0] ? 8'd255 : 8'd0;
                end
                n_phase = (r_phase == 2'd0) ? 2'd1 : 2'd0;
            end
            default: ;
        endcase
    end

    // Dithered PWM compare; the dither counter advances by one each step.
    assign n_dither = r_dither + 4'd1;
    always_comb begin
        thr[0] = {1'b0, r_scaled[0] + ((n_dither < 4'd8)  ? 8'd1 : 8'd0)};
        thr[1] = {1'b0, r_scaled[1] + ((n_dither < 4'd4)  ? 8'd1 : 8'd0)};
        thr[2] = {1'b0, r_scaled[2] + ((n_dither < 4'd12) ? 8'd1 : 8'd0)};
        for (int i = 0; i < 3; i++) begin
            n_pins[i] = thr[i] > {1'b0, r_pwm};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern  <= PAT_WAVE;
            r_period   <= PERIOD_RESET;
            r_pct      <= INTENSITY_RESET;
            r_rev      <= 1'b0;
            r_last     <= '0;
            r_phase    <= '0;
            r_sub      <= '0;
            r_pos      <= '0;
            r_seed     <= LCG_SEED_RESET;
            r_pwm      <= '0;
            r_dither   <= '0;
            r_pins     <= '0;
            r_draw_cnt <= '0;
            for (int i = 0; i < 3; i++) begin
                r_lvl[i]    <= '0;
                r_scaled[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PATTERN: begin
                        if (i_cfg_wdata[3:0] <= PAT_LAST) begin
                            r_pattern <= i_cfg_wdata[3:0];
                            r_phase   <= '0;
                            r_sub     <= '0;
                            r_pos     <= '0;
                        end
                    end
                    CFG_PERIOD:    r_period <= i_cfg_wdata;
                    CFG_INTENSITY: begin
                        if (i_cfg_wdata[6:0] <= INTENSITY_MAX) begin
                            r_pct <= i_cfg_wdata[6:0];
                        end
                    end
                    CFG_REVERSE:   r_rev <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_cmd.capture) begin
                r_draw_cnt <= '0;
            end
            if (i_cmd.draw) begin
                r_seed     <= n_seed;
                r_draw_cnt <= r_draw_cnt + 2'd1;
            end
            if (i_cmd.apply) begin
                r_last  <= r_tick;
                r_phase <= n_phase;
                r_sub   <= n_sub;
                r_pos   <= n_pos;
                for (int i = 0; i < 3; i++) begin
                    r_lvl[i] <= n_lvl[i];
                end
            end
            if (i_cmd.divide) begin
                for (int i = 0; i < 3; i++) begin
                    r_scaled[i] <= 8'(({16'd0, r_prod[i]} * {15'd0, RCP_100}) >> PCT_SHIFT);
                end
            end
            if (i_cmd.pwm) begin
                r_dither <= n_dither;
                r_pins   <= n_pins;
                r_pwm    <= r_pwm + 8'd1;
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_tick <= i_tick_now;
        end
        if (i_cmd.check) begin
            r_stepped <= o_status.step_due;
        end
        if (i_cmd.draw) begin
            case (r_draw_cnt)
                2'd0:    r_draw[0] <= n_seed[23:16];
                2'd1:    r_draw[1] <= n_seed[23:16];
                default: r_draw[2] <= n_seed[23:16];
            endcase
        end
        if (i_cmd.scale) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= {7'd0, r_lvl[i]} * {8'd0, r_pct};
            end
        end
        if (i_cmd.load_out) begin
            o_stepped     <= r_stepped;
            o_red_level   <= r_scaled[0];
            o_green_level <= r_scaled[1];
            o_blue_level  <= r_scaled[2];
            o_red_pin     <= r_pins[0];
            o_green_pin   <= r_pins[1];
            o_blue_pin    <= r_pins[2];
        end
    end

    `RGBPE_ASSERT_IMP(a_pattern_legal, i_clk, i_rst_n, 1'b1, r_pattern <= PAT_LAST)
    `RGBPE_ASSERT_IMP(a_phase_legal, i_clk, i_rst_n, 1'b1, r_phase != 2'd3)
    `RGBPE_ASSERT_NXT(a_draw_advances, i_clk, i_rst_n, i_cmd.draw, r_seed != $past(r_seed) || r_draw_cnt != $past(r_draw_cnt))

endmodule

@@ hw/rtl/rgb_led_pattern_engine.sv @@
// Top level of the RGB LED pattern engine: sequencer plus datapath.
// Depends on rgbpe_pkg, rgbpe_ctrl and rgbpe_dp.
//
//   Channel   Handshake             Payload
//   input     i_valid / o_ready     i_tick_now
//   result    o_valid / i_ready     o_stepped, o_*_level, o_*_pin
//   config    i_cfg_we (no wait)    i_cfg_addr, i_cfg_wdata
//
// An item whose tick is not yet due passes only the check and done states.
// A due item also passes the apply, scale, divide and PWM states, and a
// draw and a check state per LCG draw (up to three for sparkle, two for
// fire), since the draws share one 32-bit multiplier.
// Reset is synchronous and active low; there is no clearing pass.
// A stalled result holds the sequencer in its last state until taken.
`timescale 1ns / 1ps
module rgb_led_pattern_engine
    import rgbpe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [31:0]           i_tick_now,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_stepped,
    output logic [7:0]            o_red_level,
    output logic [7:0]            o_green_level,
    output logic [7:0]            o_blue_level,
    output logic                  o_red_pin,
    output logic                  o_green_pin,
    output logic                  o_blue_pin,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    // The sequencer walks check, draws, pattern update, scale and PWM.
    rgbpe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // The datapath holds the data registers of the engine and the result item.
    rgbpe_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_tick_now    (i_tick_now),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_stepped     (o_stepped),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_blue_level  (o_blue_level),
        .o_red_pin     (o_red_pin),
        .o_green_pin   (o_green_pin),
        .o_blue_pin    (o_blue_pin)
    );

endmodule
